@@ sv/jes_pkg.sv @@
`timescale 1ns / 1ps

package jes_pkg;

    localparam int SIZE_W = 18;
    localparam int POS_W  = 19;
    localparam int NMP_W  = 20;
    localparam int LEN_W  = 16;

    localparam logic [7:0] MK_FILL = 8'hFF;
    localparam logic [7:0] MK_SOI  = 8'hD8;
    localparam logic [7:0] MK_EOI  = 8'hD9;
    localparam logic [7:0] MK_RST0 = 8'hD0;
    localparam logic [7:0] MK_RST7 = 8'hD7;
    localparam logic [7:0] MK_SOS  = 8'hDA;
    localparam logic [7:0] MK_APP1 = 8'hE1;

    localparam logic [2:0] ST_END     = 3'd0;
    localparam logic [2:0] ST_SOS     = 3'd1;
    localparam logic [2:0] ST_BAD_LEN = 3'd2;
    localparam logic [2:0] ST_NO_SOI  = 3'd3;
    localparam logic [2:0] ST_SHORT   = 3'd4;

    typedef struct packed {
        logic              cand;
        logic [SIZE_W-1:0] poff;
        logic [LEN_W-1:0]  plen;
        logic              done;
        logic [2:0]        status;
    } t_result;

    // "Exif\0\0", indexed by check step 1..6
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        b = 8'h00;
        unique case (idx)
            3'd1:    b = 8'h45;
            3'd2:    b = 8'h78;
            3'd3:    b = 8'h69;
            3'd4:    b = 8'h66;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ sv/jes_scan_core.sv @@
`timescale 1ns / 1ps

module jes_scan_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic [7:0]              i_byte,
    input  logic                    i_first,
    input  logic                    i_last,
    input  logic [jes_pkg::SIZE_W-1:0] i_size,
    output logic                    o_res_valid,
    output jes_pkg::t_result        o_res
);
    import jes_pkg::*;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_SOI0  = 3'd1;
    localparam logic [2:0] PH_SOI1  = 3'd2;
    localparam logic [2:0] PH_SEEK  = 3'd3;
    localparam logic [2:0] PH_MARK  = 3'd4;
    localparam logic [2:0] PH_LENHI = 3'd5;
    localparam logic [2:0] PH_LENLO = 3'd6;
    localparam logic [2:0] PH_DRAIN = 3'd7;

    logic [2:0]       r_phase, n_phase;
    logic [POS_W-1:0] r_pos,   n_pos;
    logic [NMP_W-1:0] r_nmp,   n_nmp;
    logic [7:0]       r_mc,    n_mc;
    logic [LEN_W-1:0] r_seg,   n_seg;
    logic [2:0]       r_sig,   n_sig;

    t_result          res;

    always_comb begin
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  poff;
        logic [POS_W-1:0]  room;
        logic [NMP_W-1:0]  tgt;
        logic              set_en;
        logic              end_en;
        logic              fin_en;
        logic [2:0]        fin_st;
        logic [NMP_W:0]    size_x;

        n_phase = r_phase;
        n_pos   = r_pos;
        n_nmp   = r_nmp;
        n_mc    = r_mc;
        n_seg   = r_seg;
        n_sig   = r_sig;
        res     = '0;
        pos     = '0;
        poff    = '0;
        room    = '0;
        tgt     = '0;
        set_en  = 1'b0;
        end_en  = 1'b0;
        fin_en  = 1'b0;
        fin_st  = ST_END;
        size_x  = {{(NMP_W+1-SIZE_W){1'b0}}, i_size};

        if (i_step) begin
            if (i_first) begin
                n_phase = PH_SOI0;
                n_pos   = '0;
                n_nmp   = NMP_W'(2);
                n_mc    = '0;
                n_seg   = '0;
                n_sig   = '0;
            end
            if (n_phase != PH_IDLE) begin
                pos = n_pos;

                if (n_sig >= 3'd1 && n_sig <= 3'd6) begin
                    if (i_byte == sig_byte(n_sig)) begin
                        if (n_sig == 3'd6) begin
                            n_sig    = '0;
                            res.cand = 1'b1;
                            poff     = pos - POS_W'(5);
                            room     = ({1'b0, i_size} > poff) ?
                                       ({1'b0, i_size} - poff) : '0;
                            res.poff = poff[SIZE_W-1:0];
                            res.plen = n_seg - LEN_W'(2);
                            if ({{(POS_W-LEN_W){1'b0}}, res.plen} > room)
                                res.plen = room[LEN_W-1:0];
                        end else begin
                            n_sig = n_sig + 3'd1;
                        end
                    end else begin
                        n_sig = '0;
                    end
                end else begin
                    n_sig = '0;
                end

                unique case (n_phase)
                    PH_SOI0: begin
                        if (i_size < SIZE_W'(4)) begin
                            fin_en = 1'b1;
                            fin_st = ST_SHORT;
                        end else if (i_byte != MK_FILL) begin
                            fin_en = 1'b1;
                            fin_st = ST_NO_SOI;
                        end else begin
                            n_phase = PH_SOI1;
                        end
                    end
                    PH_SOI1: begin
                        if (i_byte != MK_SOI) begin
                            fin_en = 1'b1;
                            fin_st = ST_NO_SOI;
                        end else begin
                            set_en = 1'b1;
                            tgt    = NMP_W'(2);
                        end
                    end
                    PH_SEEK: begin
                        if ({1'b0, n_nmp} + (NMP_W+1)'(4) > size_x) begin
                            end_en = 1'b1;
                        end else if ({1'b0, pos} >= n_nmp) begin
                            if (i_byte == MK_FILL) begin
                                n_phase = PH_MARK;
                            end else begin
                                set_en = 1'b1;
                                tgt    = {1'b0, pos} + NMP_W'(1);
                            end
                        end
                    end
                    PH_MARK: begin
                        if (i_byte == MK_FILL) begin
                            n_nmp = {1'b0, pos};
                            if ({2'b0, pos} + (NMP_W+1)'(4) > size_x)
                                end_en = 1'b1;
                        end else if (i_byte == MK_SOI || i_byte == MK_EOI ||
                                     (i_byte >= MK_RST0 && i_byte <= MK_RST7)) begin
                            set_en = 1'b1;
                            tgt    = {1'b0, pos} + NMP_W'(1);
                        end else if (i_byte == MK_SOS) begin
                            fin_en = 1'b1;
                            fin_st = ST_SOS;
                        end else begin
                            n_mc    = i_byte;
                            n_phase = PH_LENHI;
                        end
                    end
                    PH_LENHI: begin
                        n_seg   = {i_byte, 8'h00};
                        n_phase = PH_LENLO;
                    end
                    PH_LENLO: begin
                        n_seg = {n_seg[LEN_W-1:8], i_byte};
                        if (n_seg < LEN_W'(2)) begin
                            fin_en = 1'b1;
                            fin_st = ST_BAD_LEN;
                        end else begin
                            if (n_mc == MK_APP1 &&
                                {2'b0, pos} + (NMP_W+1)'(7) <= size_x)
                                n_sig = 3'd1;
                            set_en = 1'b1;
                            tgt    = {1'b0, pos} - NMP_W'(1)
                                   + {{(NMP_W-LEN_W){1'b0}}, n_seg};
                        end
                    end
                    PH_DRAIN: begin
                        if (n_sig == '0)
                            fin_en = 1'b1;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase

                if (set_en) begin
                    n_nmp = tgt;
                    if ({1'b0, tgt} + (NMP_W+1)'(4) > size_x)
                        end_en = 1'b1;
                    else
                        n_phase = PH_SEEK;
                end
                if (end_en) begin
                    if (n_sig != '0)
                        n_phase = PH_DRAIN;
                    else
                        fin_en = 1'b1;
                end
                if (i_last && !fin_en && n_phase != PH_IDLE) begin
                    n_sig  = '0;
                    fin_en = 1'b1;
                    fin_st = ST_END;
                end
                if (fin_en) begin
                    n_phase    = PH_IDLE;
                    res.done   = 1'b1;
                    res.status = fin_st;
                    if (fin_st != ST_END)
                        n_sig = '0;
                end
                n_pos = pos + POS_W'(1);
            end
        end
    end

    assign o_res       = res;
    assign o_res_valid = res.cand | res.done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= '0;
            r_nmp   <= NMP_W'(2);
            r_mc    <= '0;
            r_seg   <= '0;
            r_sig   <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_nmp   <= n_nmp;
            r_mc    <= n_mc;
            r_seg   <= n_seg;
            r_sig   <= n_sig;
        end
    end

`ifndef SYNTHESIS
    a_idle_no_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_sig == '0)
        else $error("signature check left running after scan end");

    a_drain_has_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DRAIN |-> r_sig != '0)
        else $error("drain without a pending signature check");

    a_status_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.done) |-> o_res.status == ST_END)
        else $error("status set without scan end");

    a_done_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.done) |=> r_phase == PH_IDLE || $past(i_first) == 1'b0)
        else $error("scan still open after final status");
`endif

endmodule

@@ sv/jes_out_stage.sv @@
`timescale 1ns / 1ps

module jes_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  jes_pkg::t_result i_res,
    output logic             o_can_load,
    output logic             o_tvalid,
    input  logic             i_tready,
    output jes_pkg::t_result o_res
);
    import jes_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_can_load = !r_valid || i_tready;
    assign o_tvalid   = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

@@ sv/jpeg_exif_segment_locator.sv @@
`timescale 1ns / 1ps
// channel   | direction | tdata                      | tuser                 | tlast
// s_axis    | in        | [7:0] data_byte            | [0] first_byte        | last_byte
// m_axis    | out       | [17:0] payload_offset,     | [0] candidate_valid,  | scan_done
//           |           | [33:18] payload_length     | [3:1] done_status     |
// cfg       | in        | [17:0] buffer_length, written when i_cfg_wr_en is high
//
// One byte per cycle while m_axis does not stall. Each item passes an input
// register, combinational marker/length/signature logic, and an output
// register, which holds the result for m_axis.
// At most one result per item; items that give no result leave no output.
// Reset (synchronous, active low) returns the scanner to idle.
// A stalled m_axis holds the output register; the input side stalls only
// while both registers are full.

module jpeg_exif_segment_locator #(
    parameter int MAX_BUFFER_BYTES = 131072
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [17:0] i_cfg_wr_data,  // buffer_length
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata, // [7:0] data_byte
    input  logic [0:0]  i_s_axis_tuser, // [0] first_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata, // [17:0] payload_offset, [33:18] payload_length
    output logic [3:0]  o_m_axis_tuser, // [0] candidate_valid, [3:1] done_status
    output logic        o_m_axis_tlast
);
    import jes_pkg::*;

    localparam logic [24:0] MAX_SZ = 25'(MAX_BUFFER_BYTES);

    logic [SIZE_W-1:0] r_len;
    logic [SIZE_W-1:0] size;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_first;
    logic              r_in_last;
    logic              can_load;
    logic              step;
    logic              res_valid;
    t_result           res;
    t_result           out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cfg_wr_en) begin
            r_len <= i_cfg_wr_data;
        end
    end

    assign size = ({7'b0, r_len} > MAX_SZ) ? MAX_SZ[SIZE_W-1:0] : r_len;

    assign step            = r_in_valid && can_load;
    assign o_s_axis_tready = !r_in_valid || can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte  <= i_s_axis_tdata;
            r_in_first <= i_s_axis_tuser[0];
            r_in_last  <= i_s_axis_tlast;
        end
    end

    jes_scan_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_byte     (r_in_byte),
        .i_first    (r_in_first),
        .i_last     (r_in_last),
        .i_size     (size),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    jes_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (res_valid),
        .i_res     (res),
        .o_can_load(can_load),
        .o_tvalid  (o_m_axis_tvalid),
        .i_tready  (i_m_axis_tready),
        .o_res     (out_res)
    );

    assign o_m_axis_tdata = {6'b0, out_res.plen, out_res.poff};
    assign o_m_axis_tuser = {out_res.status, out_res.cand};
    assign o_m_axis_tlast = out_res.done;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import jes_pkg::*;

    localparam int          MAX_BYTES  = 131072;
    localparam int          ITEMS      = 1450;
    localparam int          LIMIT      = 400000;
    localparam logic [47:0] EXIF_SIG   = 48'h45_78_69_66_00_00;
    localparam int          DRAIN_CYC  = 6;
    localparam int          LONG_HOLD  = 400;

    typedef enum logic [3:0] {
        SC_IDLE, SC_SOI_HI, SC_SOI_LO, SC_SEEK, SC_MARKER, SC_LEN_HI, SC_LEN_LO, SC_DRAIN
    } t_scan_phase;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [17:0]       cfg_wr_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = '0;
    logic [0:0]        s_tuser = '0;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [39:0]       m_tdata;
    logic [3:0]        m_tuser;
    logic              m_tlast;

    // scanner state as predicted
    t_scan_phase       sc_phase = SC_IDLE;
    logic [POS_W-1:0]  sc_pos = '0;
    logic [NMP_W-1:0]  sc_next = NMP_W'(2);
    logic [7:0]        sc_marker = '0;
    logic [LEN_W-1:0]  sc_seglen = '0;
    logic [2:0]        sc_sig = '0;
    logic [SIZE_W-1:0] buf_len = '0;
    bit                r_done;
    logic [2:0]        r_status;

    t_result           expected_q[$];
    logic [7:0]        img_q[$];
    int                fails = 0;
    int                cycles = 0;
    int                bytes_sent = 0;
    int                results_due = 0;
    int                scans = 0;
    int                n_cand = 0;
    int                n_done = 0;
    int                burst_left = 0;
    bit                long_hold_req = 1'b0;

    jpeg_exif_segment_locator #(
        .MAX_BUFFER_BYTES(MAX_BYTES)
    ) u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    always #4 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------- predictor ----------------
    function automatic void close_scan(input logic [2:0] st);
        sc_phase = SC_IDLE;
        r_done = 1'b1;
        r_status = st;
        if (st != ST_END) sc_sig = '0;
    endfunction

    function automatic void reach_end();
        if (sc_sig != 0) sc_phase = SC_DRAIN;
        else close_scan(ST_END);
    endfunction

    function automatic void goto_marker(input int unsigned n, input int unsigned size);
        sc_next = n[NMP_W-1:0];
        if (n + 4 > size) reach_end();
        else sc_phase = SC_SEEK;
    endfunction

    function automatic bit scan_byte(input logic [7:0] b, input logic first,
                                     input logic last, output t_result res);
        int unsigned      size;
        int unsigned      pos;
        int unsigned      room;
        logic [17:0]      poff;
        logic [LEN_W-1:0] plen;
        bit               cand;
        res = '0;
        cand = 1'b0;
        poff = '0;
        plen = '0;
        r_done = 1'b0;
        r_status = ST_END;
        size = (buf_len > MAX_BYTES) ? MAX_BYTES : buf_len;
        if (first) begin
            sc_phase = SC_SOI_HI;
            sc_pos = '0;
            sc_next = NMP_W'(2);
            sc_marker = '0;
            sc_seglen = '0;
            sc_sig = '0;
            scans++;
        end
        if (sc_phase == SC_IDLE) return 1'b0;
        pos = sc_pos;

        if (sc_sig >= 1 && sc_sig <= 6) begin
            if (b == EXIF_SIG[55 - 8*sc_sig -: 8]) begin
                if (sc_sig == 6) begin
                    sc_sig = '0;
                    cand = 1'b1;
                    poff = 18'(pos - 5);
                    plen = sc_seglen - LEN_W'(2);
                    room = (size > poff) ? size - poff : 0;
                    if (plen > room) plen = LEN_W'(room);
                end else begin
                    sc_sig = sc_sig + 3'd1;
                end
            end else begin
                sc_sig = '0;
            end
        end else begin
            sc_sig = '0;
        end

        case (sc_phase)
            SC_SOI_HI: begin
                if (size < 4) close_scan(ST_SHORT);
                else if (b != MK_FILL) close_scan(ST_NO_SOI);
                else sc_phase = SC_SOI_LO;
            end
            SC_SOI_LO: begin
                if (b != MK_SOI) close_scan(ST_NO_SOI);
                else goto_marker(2, size);
            end
            SC_SEEK: begin
                if (sc_next + 4 > size) reach_end();
                else if (pos >= sc_next) begin
                    if (b == MK_FILL) sc_phase = SC_MARKER;
                    else goto_marker(pos + 1, size);
                end
            end
            SC_MARKER: begin
                if (b == MK_FILL) begin
                    sc_next = NMP_W'(pos);
                    if (pos + 4 > size) reach_end();
                end else if (b == MK_SOI || b == MK_EOI || (b >= MK_RST0 && b <= MK_RST7)) begin
                    goto_marker(pos + 1, size);
                end else if (b == MK_SOS) begin
                    close_scan(ST_SOS);
                end else begin
                    sc_marker = b;
                    sc_phase = SC_LEN_HI;
                end
            end
            SC_LEN_HI: begin
                sc_seglen = {b, 8'h00};
                sc_phase = SC_LEN_LO;
            end
            SC_LEN_LO: begin
                sc_seglen = {sc_seglen[15:8], b};
                if (sc_seglen < 2) begin
                    close_scan(ST_BAD_LEN);
                end else begin
                    if (sc_marker == MK_APP1 && pos + 7 <= size) sc_sig = 3'd1;
                    goto_marker(pos - 1 + sc_seglen, size);
                end
            end
            SC_DRAIN: begin
                if (sc_sig == 0) close_scan(ST_END);
            end
            default: sc_phase = SC_IDLE;
        endcase

        if (last && sc_phase != SC_IDLE) begin
            sc_sig = '0;
            close_scan(ST_END);
        end
        sc_pos = sc_pos + 1'b1;

        res.cand = cand;
        res.poff = poff;
        res.plen = plen;
        res.done = r_done;
        res.status = r_done ? r_status : ST_END;
        return cand || r_done;
    endfunction

    // ---------------- result checker ----------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk) begin
        t_result e;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: tdata %h tuser %h", m_tdata, m_tuser);
                fails++;
            end else begin
                e = expected_q.pop_front();
                check_field("candidate_valid", e.cand, m_tuser[0]);
                check_field("payload_offset", e.poff, m_tdata[17:0]);
                check_field("payload_length", e.plen, m_tdata[33:18]);
                check_field("scan_done", e.done, m_tlast);
                check_field("done_status", e.status, m_tuser[3:1]);
                n_cand += m_tuser[0];
                n_done += m_tlast;
            end
        end
    end

    // ---------------- receiver ----------------
    initial begin : rx_stall
        int hold;
        int mode;
        int mode_left;
        hold = 0;
        mode = 0;
        mode_left = 0;
        forever begin
            @(negedge clk);
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end
            if (hold > 0) begin
                hold--;
                m_tready = 1'b0;
            end else begin
                case (mode)
                    0:       m_tready = 1'b1;
                    1:       m_tready = ($urandom_range(0, 3) != 0);
                    2:       m_tready = ($urandom_range(0, 3) == 0);
                    default: m_tready = ((mode_left % 8) < 5);
                endcase
            end
        end
    end

    // ---------------- sender ----------------
    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        t_result res;
        int      gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tdata = b;
        s_tuser = first;
        s_tlast = last;
        do @(posedge clk); while (!s_tready);
        if (scan_byte(b, first, last, res)) begin
            expected_q.push_back(res);
            results_due++;
        end
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [SIZE_W-1:0] v);
        wait_drained();
        cfg_wr_en = 1'b1;
        cfg_wr_data = v;
        buf_len = v;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic send_run(input int n, input int cut);
        for (int k = 0; k < cut; k++) send_byte(img_q[k], k == 0, k == n - 1);
        bytes_sent += cut;
    endtask

    // builds a mostly well-formed marker stream of n bytes into img_q
    task automatic make_jpeg(input int n);
        int         kind;
        int         len;
        int         bad;
        logic [7:0] m;
        logic [7:0] sb;
        img_q.delete();
        if ($urandom_range(0, 19) == 0) begin
            img_q.push_back(8'($urandom_range(0, 255)));
            img_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            img_q.push_back(MK_FILL);
            img_q.push_back(MK_SOI);
        end
        while (img_q.size() < n) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                case ($urandom_range(0, 9))
                    0, 1:    len = $urandom_range(2, 7);
                    2:       len = ($urandom_range(0, 1) == 0) ? 16'hFFFF
                                                               : $urandom_range(300, 65535);
                    default: len = $urandom_range(8, 40);
                endcase
                bad = (kind < 30) ? -1 : $urandom_range(0, 5);
                img_q.push_back(MK_FILL);
                img_q.push_back(MK_APP1);
                img_q.push_back(8'(len >> 8));
                img_q.push_back(8'(len));
                for (int k = 0; k < 6; k++) begin
                    sb = EXIF_SIG[47 - 8*k -: 8];
                    if (k == bad) sb ^= 8'($urandom_range(1, 255));
                    img_q.push_back(sb);
                end
                for (int k = 8; k < len && img_q.size() < n; k++)
                    img_q.push_back(8'($urandom_range(0, 255)));
            end else if (kind < 55) begin
                do m = 8'($urandom_range(8'hC0, 8'hFE)); while (m >= MK_RST0 && m <= MK_SOS);
                len = $urandom_range(2, 24);
                img_q.push_back(MK_FILL);
                img_q.push_back(m);
                img_q.push_back(8'(len >> 8));
                img_q.push_back(8'(len));
                for (int k = 2; k < len && img_q.size() < n; k++)
                    img_q.push_back(8'($urandom_range(0, 255)));
            end else if (kind < 65) begin
                repeat ($urandom_range(1, 3)) img_q.push_back(MK_FILL);
            end else if (kind < 75) begin
                img_q.push_back(MK_FILL);
                img_q.push_back(MK_RST0 + 8'($urandom_range(0, 9)));
            end else if (kind < 79) begin
                img_q.push_back(MK_FILL);
                img_q.push_back(MK_SOS);
            end else if (kind < 83) begin
                img_q.push_back(MK_FILL);
                img_q.push_back(8'hC4);
                img_q.push_back(8'h00);
                img_q.push_back(8'($urandom_range(0, 1)));
            end else begin
                repeat ($urandom_range(1, 4)) img_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        while (img_q.size() > n) void'(img_q.pop_back());
    endtask

    // ---------------- tests ----------------
    task automatic test_short_buffer();
        cfg_write(18'd3);
        send_byte(MK_FILL, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);   // idle, ignored
    endtask

    task automatic test_no_soi_restart_early_last();
        cfg_write(18'h3FFFF);
        send_byte(8'h00, 1'b1, 1'b0);
        cfg_write(SIZE_W'(MAX_BYTES));
        img_q = '{MK_FILL, MK_SOI, MK_FILL};
        send_run(8, 3);
        // APP1 of max length, last byte lands mid-signature
        img_q = '{MK_FILL, MK_SOI, MK_FILL, MK_APP1, 8'hFF, 8'hFF, 8'h45, 8'h78};
        send_run(8, 8);
    endtask

    task automatic test_overlapping_signature();
        cfg_write(18'd12);
        // length 2 puts the walk inside the signature; end held until it resolves
        img_q = '{MK_FILL, MK_SOI, MK_FILL, MK_APP1, 8'h00, 8'h02,
                  8'h45, 8'h78, 8'h69, 8'h66, 8'h00, 8'h00};
        send_run(12, 12);
    endtask

    task automatic test_output_backpressure();
        cfg_write(18'd0);
        long_hold_req = 1'b1;
        repeat (24) send_byte(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
        bytes_sent += 24;
        wait_drained();
    endtask

    task automatic test_random_scans();
        int unsigned size;
        int          nbuf;
        int          n;
        int          cut;
        int          r;
        while (bytes_sent < ITEMS || results_due < 60) begin
            r = $urandom_range(0, 99);
            if (r < 10) size = $urandom_range(0, 7);
            else if (r < 88) size = $urandom_range(8, 120);
            else if (r < 93) size = $urandom_range(121, 250);
            else begin
                case ($urandom_range(0, 3))
                    0:       size = MAX_BYTES;
                    1:       size = 18'h3FFFF;
                    2:       size = $urandom_range(MAX_BYTES + 1, 18'h3FFFF);
                    default: size = $urandom_range(1000, MAX_BYTES);
                endcase
            end
            cfg_write(SIZE_W'(size));
            nbuf = $urandom_range(2, 6);
            for (int i = 0; i < nbuf; i++) begin
                if (size > 250) begin
                    n = $urandom_range(20, 90);
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 15) n = $urandom_range(1, (size == 0) ? 1 : size);
                    else if (r < 25) n = size + $urandom_range(1, 6);
                    else n = (size == 0) ? 1 : size;
                end
                make_jpeg(n);
                // cut-off run, restarted by the next one
                cut = (i < nbuf - 1 && n > 2 && $urandom_range(0, 9) == 0)
                      ? $urandom_range(1, n - 1) : n;
                send_run(n, cut);
                if (cut == n && $urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3))
                        send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_short_buffer();
        test_no_soi_restart_early_last();
        test_overlapping_signature();
        test_output_backpressure();
        test_random_scans();

        wait_drained();
        repeat (10) @(posedge clk);
        $display("checked %0d bytes over %0d scans: %0d Exif candidates, %0d final statuses",
                 bytes_sent, scans, n_cand, n_done);
        $display("buffer sizes from 0 up to clipped maximum, with sender gaps and output stalls");
        if (fails == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
